// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the slot ring tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is applied.
`define TCSRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define TCSRT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tcsrt_pkg.sv =====
// Shared types and constants of the two-cursor slot ring tracker.
package tcsrt_pkg;

	localparam int MAX_SLOTS_DFLT = 256;
	localparam int COUNT_W        = 9;
	localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		MODE_CLAIM_FILL   = 2'd0,
		MODE_CLAIM_DRAIN  = 2'd1,
		MODE_MARK_FILLED  = 2'd2,
		MODE_MARK_DRAINED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		SLOT_FREE     = 3'd0,
		SLOT_FILLING  = 3'd1,
		SLOT_FILLED   = 3'd2,
		SLOT_DRAINING = 3'd3,
		SLOT_DRAINED  = 3'd4
	} slot_state_t;

	typedef enum logic [1:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_DECIDE
	} ctl_state_t;

	typedef struct packed {
		logic in_ready;
		logic lookup;
		logic clear_wr;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/tcsrt_ifs.sv =====
// Request and response channel interfaces of the slot ring tracker.
interface tcsrt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] slot_index;

	modport source (output valid, output mode, output slot_index, input ready);
	modport sink (input valid, input mode, input slot_index, output ready);
endinterface

interface tcsrt_rsp_if;
	logic       valid;
	logic       ready;
	logic       granted;
	logic [7:0] claimed_slot;
	logic [2:0] slot_state_seen;
	logic       index_error;

	modport source (output valid, output granted, output claimed_slot,
		output slot_state_seen, output index_error, input ready);
	modport sink (input valid, input granted, input claimed_slot,
		input slot_state_seen, input index_error, output ready);
endinterface

// ===== design/tcsrt_ctrl.sv =====
// Controller of the slot ring tracker: clear sweep, accept and decide sequencing.
module tcsrt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tcsrt_pkg::dp_status_t status,
	output tcsrt_pkg::ctl_cmd_t   cmd
);

	tcsrt_pkg::ctl_state_t state_q;
	tcsrt_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcsrt_pkg::CTL_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.in_ready = 1'b0;
		cmd.lookup   = 1'b0;
		cmd.clear_wr = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			tcsrt_pkg::CTL_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = tcsrt_pkg::CTL_IDLE;
				end
			end
			tcsrt_pkg::CTL_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.lookup = 1'b1;
					state_d    = tcsrt_pkg::CTL_DECIDE;
				end
			end
			tcsrt_pkg::CTL_DECIDE: begin
				// hold the decision until the response register can take it
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = tcsrt_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = tcsrt_pkg::CTL_CLEAR;
			end
		endcase
	end

endmodule

// ===== design/tcsrt_dp.sv =====
// Datapath of the slot ring tracker: slot state memory, cursors, response register.
module tcsrt_dp #(
	parameter int MAX_SLOTS = tcsrt_pkg::MAX_SLOTS_DFLT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tcsrt_pkg::ctl_cmd_t                   cmd,
	output tcsrt_pkg::dp_status_t                 status,
	input  logic                                  slot_count_we,
	input  logic [tcsrt_pkg::COUNT_W-1:0]         slot_count_wdata,
	input  logic [1:0]                            in_mode,
	input  logic [7:0]                            in_slot_index,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  out_granted,
	output logic [7:0]                            out_claimed_slot,
	output logic [2:0]                            out_slot_state_seen,
	output logic                                  out_index_error
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = ($clog2(MAX_SLOTS + 1) > tcsrt_pkg::COUNT_W) ?
		$clog2(MAX_SLOTS + 1) : tcsrt_pkg::COUNT_W;

	logic [2:0]                    slot_mem [MAX_SLOTS];
	logic [2:0]                    rd_data_q;
	logic [tcsrt_pkg::COUNT_W-1:0] slot_count_q;
	logic [AW-1:0]                 fill_cur_q;
	logic [AW-1:0]                 drain_cur_q;
	logic [AW-1:0]                 clr_cnt_q;
	tcsrt_pkg::mode_t              mode_q;
	logic [7:0]                    idx_q;
	logic                          out_valid_q;
	logic                          out_granted_q;
	logic [7:0]                    out_slot_q;
	logic [2:0]                    out_seen_q;
	logic                          out_err_q;

	logic [NW-1:0] cnt_ext;
	logic [NW-1:0] n_eff;
	logic [AW-1:0] fill_eff;
	logic [AW-1:0] drain_eff;
	logic [NW-1:0] fill_inc;
	logic [NW-1:0] drain_inc;
	logic [AW-1:0] fill_next;
	logic [AW-1:0] drain_next;
	logic [NW-1:0] in_idx_ext;
	logic [NW-1:0] idx_ext;
	logic [AW-1:0] rd_addr;
	tcsrt_pkg::mode_t in_mode_e;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [2:0]    wr_data;
	logic          grant_d;
	logic [AW-1:0] slot_d;
	logic [2:0]    seen_d;
	logic          err_d;
	logic          fill_adv;
	logic          drain_adv;

	// effective count: zero reads as one, anything above the ring size clamps
	assign cnt_ext = NW'(slot_count_q);
	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = NW'(1);
		end else if (cnt_ext > NW'(MAX_SLOTS)) begin
			n_eff = NW'(MAX_SLOTS);
		end else begin
			n_eff = cnt_ext;
		end
	end

	// a cursor left beyond a shrunken count reads as slot zero
	assign fill_eff   = (NW'(fill_cur_q) < n_eff) ? fill_cur_q : '0;
	assign drain_eff  = (NW'(drain_cur_q) < n_eff) ? drain_cur_q : '0;
	assign fill_inc   = NW'(fill_eff) + NW'(1);
	assign drain_inc  = NW'(drain_eff) + NW'(1);
	assign fill_next  = (fill_inc >= n_eff) ? '0 : fill_inc[AW-1:0];
	assign drain_next = (drain_inc >= n_eff) ? '0 : drain_inc[AW-1:0];

	assign in_mode_e  = tcsrt_pkg::mode_t'(in_mode);
	assign in_idx_ext = NW'(in_slot_index);
	assign idx_ext    = NW'(idx_q);

	always_comb begin
		case (in_mode_e)
			tcsrt_pkg::MODE_CLAIM_FILL:  rd_addr = fill_eff;
			tcsrt_pkg::MODE_CLAIM_DRAIN: rd_addr = drain_eff;
			default:                     rd_addr = in_idx_ext[AW-1:0];
		endcase
	end

	// decision on the looked-up slot state
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_ext[AW-1:0];
		wr_data   = tcsrt_pkg::SLOT_FILLED;
		grant_d   = 1'b0;
		slot_d    = '0;
		seen_d    = '0;
		err_d     = 1'b0;
		fill_adv  = 1'b0;
		drain_adv = 1'b0;
		case (mode_q)
			tcsrt_pkg::MODE_CLAIM_FILL: begin
				seen_d  = rd_data_q;
				slot_d  = fill_eff;
				wr_addr = fill_eff;
				wr_data = tcsrt_pkg::SLOT_FILLING;
				if (rd_data_q == tcsrt_pkg::SLOT_FREE ||
				    rd_data_q == tcsrt_pkg::SLOT_DRAINED) begin
					grant_d  = 1'b1;
					wr_en    = 1'b1;
					fill_adv = 1'b1;
				end
			end
			tcsrt_pkg::MODE_CLAIM_DRAIN: begin
				seen_d  = rd_data_q;
				slot_d  = drain_eff;
				wr_addr = drain_eff;
				wr_data = tcsrt_pkg::SLOT_DRAINING;
				if (rd_data_q == tcsrt_pkg::SLOT_FILLED) begin
					grant_d   = 1'b1;
					wr_en     = 1'b1;
					drain_adv = 1'b1;
				end
			end
			default: begin
				wr_data = (mode_q == tcsrt_pkg::MODE_MARK_FILLED) ?
					tcsrt_pkg::SLOT_FILLED : tcsrt_pkg::SLOT_DRAINED;
				if (idx_ext >= n_eff) begin
					err_d = 1'b1;
				end else begin
					seen_d  = rd_data_q;
					grant_d = 1'b1;
					wr_en   = 1'b1;
				end
			end
		endcase
	end

	// slot state memory: clear sweep after reset, then at most one update per transaction
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			slot_mem[clr_cnt_q] <= tcsrt_pkg::SLOT_FREE;
		end else if (cmd.commit && wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.lookup) begin
			rd_data_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			mode_q <= in_mode_e;
			idx_q  <= in_slot_index;
		end
		if (cmd.commit) begin
			out_granted_q <= grant_d;
			out_slot_q    <= NW'(slot_d) >> 0 == '0 ? 8'd0 : 8'(NW'(slot_d));
			out_seen_q    <= seen_d;
			out_err_q     <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= tcsrt_pkg::SLOT_COUNT_RST;
			fill_cur_q   <= '0;
			drain_cur_q  <= '0;
			clr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (slot_count_we) begin
				slot_count_q <= slot_count_wdata;
			end
			if (cmd.clear_wr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.commit && fill_adv) begin
				fill_cur_q <= fill_next;
			end
			if (cmd.commit && drain_adv) begin
				drain_cur_q <= drain_next;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.clear_last = (clr_cnt_q == AW'(MAX_SLOTS - 1));
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid           = out_valid_q;
	assign out_granted         = out_granted_q;
	assign out_claimed_slot    = out_slot_q;
	assign out_slot_state_seen = out_seen_q;
	assign out_index_error     = out_err_q;

endmodule

// ===== design/two_cursor_slot_ring_tracker_core.sv =====
// Flow: an accepted request's slot state is read into a register, then decided once the
//   response register is free; a new request is accepted only after the last one has
//   been decided, and slot updates go through the single write port of the memory.
// Reset: arst_n clears cursors, slot_count (256) and the response valid flag, then a
//   clearing pass writes every slot free, with requests held off.
// Writes of slot_count are taken at any time, including during the clearing pass.
module two_cursor_slot_ring_tracker_core #(
	parameter int MAX_SLOTS = tcsrt_pkg::MAX_SLOTS_DFLT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tcsrt_req_if.sink                     req,
	tcsrt_rsp_if.source                   rsp,
	input  logic                          slot_count_we,
	input  logic [tcsrt_pkg::COUNT_W-1:0] slot_count_wdata
);

	// Controller sequences clear, accept (memory lookup) and decide (update);
	// the datapath owns the slot memory, the two cursors and the response register.
	tcsrt_pkg::ctl_cmd_t   cmd;
	tcsrt_pkg::dp_status_t status;

	tcsrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.status   (status),
		.cmd      (cmd)
	);

	// request transaction is accepted only in the idle state
	assign req.ready = cmd.in_ready;

	tcsrt_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.slot_count_we       (slot_count_we),
		.slot_count_wdata    (slot_count_wdata),
		.in_mode             (req.mode),
		.in_slot_index       (req.slot_index),
		.out_ready           (rsp.ready),
		.out_valid           (rsp.valid),
		.out_granted         (rsp.granted),
		.out_claimed_slot    (rsp.claimed_slot),
		.out_slot_state_seen (rsp.slot_state_seen),
		.out_index_error     (rsp.index_error)
	);

endmodule

// ===== design/tcsrt_chk.sv =====
// Port-level assertion checker of the slot ring tracker, bound to the top level.
`include "assert_macros.svh"

module tcsrt_chk (
	input logic         clk,
	input logic         arst_n,
	tcsrt_req_if.sink   req,
	tcsrt_rsp_if.source rsp
);

	`TCSRT_ASSERT_RST(a_rst_quiet, !arst_n |-> !req.ready && !rsp.valid, "active during reset")
	`TCSRT_ASSERT(a_one_in_flight, req.valid && req.ready |=> !req.ready, "back-to-back accept")
	`TCSRT_ASSERT(a_err_fields, rsp.valid && rsp.index_error |-> !rsp.granted && rsp.claimed_slot == 8'd0 && rsp.slot_state_seen == 3'd0, "index error with payload")
	`TCSRT_ASSERT(a_rsp_hold, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.claimed_slot), "stalled response dropped")

endmodule

bind two_cursor_slot_ring_tracker_core tcsrt_chk u_tcsrt_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the two-cursor slot ring tracker core.
module tb;
	import tcsrt_pkg::*;

	localparam int RING_MAX  = MAX_SLOTS_DFLT;
	localparam int CYC_LIMIT = 1000000;
	localparam int PHASE_LEN = 128;

	// one response transaction, field for field
	typedef struct packed {
		logic        granted;
		logic [7:0]  slot;
		slot_state_t seen;
		logic        ierr;
	} ring_rsp_t;

	// per-request note from the driver: a hand-typed response, if there is one
	typedef struct packed {
		logic      typed;
		ring_rsp_t rsp;
	} req_note_t;

	// directed row: either a slot_count write or one request
	typedef struct packed {
		logic       is_cfg;
		logic [8:0] cnt;
		mode_t      mode;
		logic [7:0] idx;
		logic       typed;
		ring_rsp_t  rsp;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       slot_count_we;
	logic [8:0] slot_count_wdata;

	tcsrt_req_if req();
	tcsrt_rsp_if rsp();

	two_cursor_slot_ring_tracker_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req),
		.rsp              (rsp),
		.slot_count_we    (slot_count_we),
		.slot_count_wdata (slot_count_wdata)
	);

	// Shadow copy of the ring: slot states, both cursors and the count register.
	slot_state_t ring_st [RING_MAX];
	int          fill_pos;
	int          drain_pos;
	logic [8:0]  count_reg;

	ring_rsp_t rsp_q  [$];   // responses still owed by the DUT, oldest first
	req_note_t note_q [$];   // driver notes, one per request not yet accepted

	int  n_req, n_rsp, n_err, n_grant, n_ierr, n_cfg;
	int  cyc;
	int  stall_left;
	bit  rsp_free;           // no new response stalls begin while set

	// Directed rows. Typed responses only where they are obvious: reset state,
	// extreme slot indexes and out-of-range marks.
	dir_row_t dir_tab [0:27] = '{
		// fresh ring, slot_count 256: drain on empty ring fails at slot 0
		'{1'b0, 9'd0, MODE_CLAIM_DRAIN, 8'd0, 1'b1, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b1, '{1'b1, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd0, 1'b1, '{1'b1, 8'd0, SLOT_FILLING, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_DRAIN, 8'd0, 1'b1, '{1'b1, 8'd0, SLOT_FILLED, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_DRAINED, 8'd0, 1'b1, '{1'b1, 8'd0, SLOT_DRAINING, 1'b0}},
		// top slot, named directly
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd255, 1'b1, '{1'b1, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_DRAINED, 8'd255, 1'b1, '{1'b1, 8'd0, SLOT_FILLED, 1'b0}},
		// shrink to 4: marks past the end are flagged
		'{1'b1, 9'd4, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd4, 1'b1, '{1'b0, 8'd0, SLOT_FREE, 1'b1}},
		'{1'b0, 9'd0, MODE_MARK_DRAINED, 8'd255, 1'b1, '{1'b0, 8'd0, SLOT_FREE, 1'b1}},
		// fill cursor walks 1..3, wraps onto the drained slot 0, then hits a filling slot
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		// single slot: drain cursor now beyond the count
		'{1'b1, 9'd1, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_DRAIN, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd1, 1'b1, '{1'b0, 8'd0, SLOT_FREE, 1'b1}},
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_DRAIN, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		// count of zero behaves as one
		'{1'b1, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_DRAINED, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		// oversized count clamps to the ring size
		'{1'b1, 9'd511, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_MARK_FILLED, 8'd255, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_FILL, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}},
		'{1'b0, 9'd0, MODE_CLAIM_DRAIN, 8'd0, 1'b0, '{1'b0, 8'd0, SLOT_FREE, 1'b0}}
	};

	// slot_count settings of the random phases, extremes and clamped values included
	logic [8:0] phase_cnt [0:11] = '{
		9'd256, 9'd8, 9'd2, 9'd1, 9'd37, 9'd0, 9'd5, 9'd300, 9'd511, 9'd3, 9'd16, 9'd256
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// effective ring size as the hardware sees it: 0 acts as 1, large values clamp
	function automatic int ring_size();
		if (count_reg == 9'd0)
			return 1;
		if (int'(count_reg) > RING_MAX)
			return RING_MAX;
		return int'(count_reg);
	endfunction

	// Apply one request to the shadow ring and return the response it must produce.
	function automatic ring_rsp_t ring_step(mode_t m, logic [7:0] idx);
		ring_rsp_t r;
		int        n;
		int        cur;
		n = ring_size();
		r = '{1'b0, 8'd0, SLOT_FREE, 1'b0};
		case (m)
			MODE_CLAIM_FILL: begin
				// a cursor left past a shrunk ring is read as slot 0
				cur = (fill_pos < n) ? fill_pos : 0;
				r.seen = ring_st[cur];
				r.slot = cur[7:0];
				if (ring_st[cur] == SLOT_FREE || ring_st[cur] == SLOT_DRAINED) begin
					r.granted = 1'b1;
					ring_st[cur] = SLOT_FILLING;
					fill_pos = (cur + 1 >= n) ? 0 : cur + 1;
				end
			end
			MODE_CLAIM_DRAIN: begin
				cur = (drain_pos < n) ? drain_pos : 0;
				r.seen = ring_st[cur];
				r.slot = cur[7:0];
				if (ring_st[cur] == SLOT_FILLED) begin
					r.granted = 1'b1;
					ring_st[cur] = SLOT_DRAINING;
					drain_pos = (cur + 1 >= n) ? 0 : cur + 1;
				end
			end
			default: begin
				// marks: claimed_slot stays zero, out-of-range index is only flagged
				if (int'(idx) >= n) begin
					r.ierr = 1'b1;
				end else begin
					r.seen = ring_st[idx];
					ring_st[idx] = (m == MODE_MARK_FILLED) ? SLOT_FILLED : SLOT_DRAINED;
					r.granted = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	// Monitor: predict on every accepted request, check every accepted response.
	always @(posedge clk) begin : mon
		req_note_t note;
		ring_rsp_t pred;
		ring_rsp_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				note = (note_q.size() != 0) ? note_q.pop_front() : '0;
				pred = ring_step(mode_t'(req.mode), req.slot_index);
				rsp_q.push_back(note.typed ? note.rsp : pred);
				n_req++;
			end
			if (rsp.valid && rsp.ready) begin
				n_rsp++;
				if (rsp_q.size() == 0) begin
					$display("%0t: response transaction with nothing outstanding", $time);
					n_err++;
				end else begin
					want = rsp_q.pop_front();
					if (rsp.granted !== want.granted) begin
						$display("%0t: granted expected %0d actual %0d",
							$time, want.granted, rsp.granted);
						n_err++;
					end
					if (rsp.claimed_slot !== want.slot) begin
						$display("%0t: claimed_slot expected %0d actual %0d",
							$time, want.slot, rsp.claimed_slot);
						n_err++;
					end
					if (rsp.slot_state_seen !== want.seen) begin
						$display("%0t: slot_state_seen expected %0d actual %0d",
							$time, want.seen, rsp.slot_state_seen);
						n_err++;
					end
					if (rsp.index_error !== want.ierr) begin
						$display("%0t: index_error expected %0d actual %0d",
							$time, want.ierr, rsp.index_error);
						n_err++;
					end
					if (want.granted)
						n_grant++;
					if (want.ierr)
						n_ierr++;
				end
			end
		end
	end

	// Response backpressure: random stalls unless a stall-free stretch is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (!rsp_free && $urandom_range(0, 99) < 20) begin
			rsp.ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached, %0d responses outstanding",
				$time, CYC_LIMIT, rsp_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// One request transaction; optional idle after it. valid stays up when gap is 0.
	task automatic send_req(mode_t m, logic [7:0] idx, logic typed, ring_rsp_t r, int gap);
		req_note_t note;
		note.typed = typed;
		note.rsp = r;
		note_q.push_back(note);
		req.valid <= 1'b1;
		req.mode <= m;
		req.slot_index <= idx;
		do
			@(posedge clk);
		while (!req.ready);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off requests until every owed response has come back.
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (rsp_q.size() != 0 || note_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(logic [8:0] v);
		wait_idle();
		slot_count_we <= 1'b1;
		slot_count_wdata <= v;
		@(posedge clk);
		slot_count_we <= 1'b0;
		count_reg = v;
		n_cfg++;
	endtask

	initial begin : stim
		int        n;
		int        r;
		int        gap;
		bit        quiet;
		mode_t     m;
		logic [7:0] idx;
		ring_rsp_t none;

		none = '{1'b0, 8'd0, SLOT_FREE, 1'b0};
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_CLAIM_FILL;
		req.slot_index <= 8'd0;
		slot_count_we <= 1'b0;
		slot_count_wdata <= SLOT_COUNT_RST;
		for (int i = 0; i < RING_MAX; i++)
			ring_st[i] = SLOT_FREE;
		fill_pos = 0;
		drain_pos = 0;
		count_reg = SLOT_COUNT_RST;
		stall_left = 0;
		rsp_free = 1'b0;
		n_req = 0;
		n_rsp = 0;
		n_err = 0;
		n_grant = 0;
		n_ierr = 0;
		n_cfg = 0;
		cyc = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part; the first request simply waits out the clearing pass.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_count(dir_tab[i].cnt);
			else
				send_req(dir_tab[i].mode, dir_tab[i].idx, dir_tab[i].typed,
					dir_tab[i].rsp, ($urandom_range(0, 1) == 0) ? 0 : pick_gap());
		end

		// Random phases, one slot_count each. Most marks name a slot just behind a
		// cursor so that fill/drain cycles actually complete; the rest are noise.
		foreach (phase_cnt[p]) begin
			write_count(phase_cnt[p]);
			quiet = (p % 3 == 1);
			rsp_free = quiet;
			for (int k = 0; k < PHASE_LEN; k++) begin
				// mid-phase stop: let the pipeline run dry before going on
				if (k == PHASE_LEN / 2 && p % 2 == 0)
					wait_idle();
				n = ring_size();
				r = $urandom_range(0, 99);
				idx = $urandom_range(0, 255);
				if (r < 30) begin
					m = MODE_CLAIM_FILL;
				end else if (r < 50) begin
					m = MODE_CLAIM_DRAIN;
				end else if (r < 75) begin
					m = MODE_MARK_FILLED;
					if ($urandom_range(0, 99) < 80)
						idx = 8'(((fill_pos - 1 - int'($urandom_range(0, 3))) % n + n) % n);
				end else begin
					m = MODE_MARK_DRAINED;
					if ($urandom_range(0, 99) < 80)
						idx = 8'(((drain_pos - 1 - int'($urandom_range(0, 3))) % n + n) % n);
				end
				gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
				send_req(m, idx, 1'b0, none, gap);
			end
		end

		rsp_free = 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (rsp_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, rsp_q.size());
			n_err++;
		end

		$display("tb: %0d requests, %0d responses checked, %0d slot_count writes",
			n_req, n_rsp, n_cfg);
		$display("tb: %0d granted, %0d index errors, %0d mismatches",
			n_grant, n_ierr, n_err);
		if (n_err == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/tcsrt_pkg.sv
design/tcsrt_ifs.sv
design/tcsrt_ctrl.sv
design/tcsrt_dp.sv
design/two_cursor_slot_ring_tracker_core.sv
design/tcsrt_chk.sv
tb/tb.sv
